>>> sv/hcf_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the heading filter.
// Used by hcf_ctrl, hcf_dp and heading_complementary_filter; depends on nothing.
`default_nettype none
package hcf_pkg;

	// Iteration count and heading resolution.
	localparam int CORDIC_ITERATIONS = 16;
	localparam int YAW_FRAC_BITS     = 7;

	// Port widths.
	localparam int IN_W   = 16;
	localparam int HEAD_W = 16;
	localparam int WGT_W  = 16;
	localparam logic [WGT_W-1:0] WGT_RESET = 16'd62259;

	// Arctangent table length and the counter that indexes it.
	localparam int TABLE_LEN = 24;
	localparam int ITER_W    = $clog2(TABLE_LEN);

	// CORDIC vector: sign-extended sample, prescaled by 256, with room for gain.
	localparam int PRE_W   = IN_W + 2;
	localparam int PRE_SH  = 8;
	localparam int X_W     = PRE_W + PRE_SH + 1;

	// Angle accumulator in units of 1/65536 degree.
	localparam int ANG_W = 26;
	localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(90 * 65536);
	localparam logic signed [ANG_W-1:0] ANG_FULL    = ANG_W'(360 * 65536);
	localparam int ANG_SH = 16 - YAW_FRAC_BITS;
	localparam logic signed [ANG_W-1:0] ANG_RND = ANG_W'(1 << (ANG_SH - 1));

	// Heading units: a full and a half circle, and the width of an unwrapped value.
	localparam int FULL  = 360 << YAW_FRAC_BITS;
	localparam int HALF  = 180 << YAW_FRAC_BITS;
	localparam int SUM_W = $clog2(2 * FULL + 1);
	localparam int D_W   = SUM_W + 1;
	localparam int P_W   = D_W + WGT_W + 1;
	localparam int A_W   = P_W + 1;
	localparam int Y_W   = A_W - WGT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ITER,
		ST_MAP,
		ST_UNWRAP,
		ST_MUL,
		ST_ADD
	} hcf_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;
		logic              iter;
		logic [ITER_W-1:0] idx;
		logic              map;
		logic              unwrap;
		logic              mul;
		logic              commit;
	} hcf_cmd_t;

	// atan(2^-i) in units of 1/65536 degree, rounded to nearest.
	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
		logic signed [ANG_W-1:0] v;
		case (i)
			5'd0:  v = ANG_W'(2949120);
			5'd1:  v = ANG_W'(1740967);
			5'd2:  v = ANG_W'(919879);
			5'd3:  v = ANG_W'(466945);
			5'd4:  v = ANG_W'(234379);
			5'd5:  v = ANG_W'(117304);
			5'd6:  v = ANG_W'(58666);
			5'd7:  v = ANG_W'(29335);
			5'd8:  v = ANG_W'(14668);
			5'd9:  v = ANG_W'(7334);
			5'd10: v = ANG_W'(3667);
			5'd11: v = ANG_W'(1833);
			5'd12: v = ANG_W'(917);
			5'd13: v = ANG_W'(458);
			5'd14: v = ANG_W'(229);
			5'd15: v = ANG_W'(115);
			5'd16: v = ANG_W'(57);
			5'd17: v = ANG_W'(29);
			5'd18: v = ANG_W'(14);
			5'd19: v = ANG_W'(7);
			5'd20: v = ANG_W'(4);
			5'd21: v = ANG_W'(2);
			5'd22: v = ANG_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> sv/heading_complementary_filter.sv
// Top level of the magnetometer heading filter with complementary blend.
// Depends on hcf_pkg, hcf_ctrl and hcf_dp.
//
//   channel   signals                          direction  payload
//   in        in_valid / in_ready              sink       mode, mag_x, mag_y
//   out       out_valid / out_ready            source     yaw
//   cfg       cfg_valid / cfg_ready            sink       cfg_data (gyro weight, Q0.16)
//
// An accepted beat runs CORDIC_ITERATIONS (16) steps of the shared CORDIC stage, then
// the angle mapping, unwrap, multiply and add states in that order; a new beat is
// taken only after the add has committed the result to yaw.
// The multiply-and-add blend uses one multiplier and registers the product between the multiply and add steps.
// Reset clears the stored heading to zero and loads the default weight.
// A result left waiting stalls the final add; configuration is always taken.
`default_nettype none
module heading_complementary_filter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             mode,
	input  wire logic signed [hcf_pkg::IN_W-1:0]  mag_x,
	input  wire logic signed [hcf_pkg::IN_W-1:0]  mag_y,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [hcf_pkg::HEAD_W-1:0]            yaw,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [hcf_pkg::WGT_W-1:0]        cfg_data
);
	import hcf_pkg::*;

	hcf_cmd_t cmd;

	assign cfg_ready = 1'b1;

	hcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	hcf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mode     (mode),
		.mag_x    (mag_x),
		.mag_y    (mag_y),
		.wgt_we   (cfg_valid),
		.wgt_data (cfg_data),
		.yaw      (yaw)
	);

endmodule
`default_nettype wire

>>> sv/hcf_ctrl.sv
// Sequencer for the heading filter: handshakes, iteration counter, output valid.
// Depends on hcf_pkg; drives the command struct of hcf_dp.
`default_nettype none
module hcf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output hcf_pkg::hcf_cmd_t     cmd
);
	import hcf_pkg::*;

	localparam logic [ITER_W-1:0] LAST = ITER_W'(CORDIC_ITERATIONS - 1);

	hcf_state_t        state_q, state_d;
	logic [ITER_W-1:0] cnt_q, cnt_d;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_ITER;
				end
			end
			ST_ITER: begin
				cmd.iter = 1'b1;
				cmd.idx  = cnt_q;
				if (cnt_q == LAST) begin
					state_d = ST_MAP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_d = ST_UNWRAP;
			end
			ST_UNWRAP: begin
				cmd.unwrap = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				// The result register doubles as the stored heading, so it may
				// only load once the previous result has been taken.
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_ITER && cnt_q == '0)
		else $error("accepted beat did not start the iteration");
	a_iter_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ITER && cnt_q == LAST |=> state_q == ST_MAP)
		else $error("iteration did not end after the last step");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ITER |-> cnt_q <= LAST)
		else $error("iteration counter out of range");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD && out_valid_q && !out_ready |=> state_q == ST_ADD)
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

>>> sv/hcf_dp.sv
// Datapath of the heading filter: iterative CORDIC atan2, angle mapping, blend.
// Depends on hcf_pkg; steered by the command struct from hcf_ctrl.
`default_nettype none
module hcf_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire hcf_pkg::hcf_cmd_t                 cmd,
	input  wire logic                              mode,
	input  wire logic signed [hcf_pkg::IN_W-1:0]   mag_x,
	input  wire logic signed [hcf_pkg::IN_W-1:0]   mag_y,
	input  wire logic                              wgt_we,
	input  wire logic [hcf_pkg::WGT_W-1:0]         wgt_data,
	output logic [hcf_pkg::HEAD_W-1:0]             yaw
);
	import hcf_pkg::*;

	localparam logic [SUM_W-1:0]         FULL_U = SUM_W'(FULL);
	localparam logic signed [SUM_W+1:0]  HALF_S = (SUM_W + 2)'(HALF);
	localparam logic signed [A_W-1:0]    BLEND_RND = A_W'(1 << (WGT_W - 1));

	logic signed [X_W-1:0]   x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic                    zero_q, mode_q;
	logic [SUM_W-1:0]        m_q, mu_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [P_W-1:0]   prod_q;
	logic [HEAD_W-1:0]       heading_q;
	logic [WGT_W-1:0]        wgt_q;

	// Load: negate y and pre-rotate a left half-plane vector by a quarter turn.
	logic signed [PRE_W-1:0] mxe, nye, x0, y0;
	logic signed [ANG_W-1:0] z0;

	always_comb begin
		mxe = PRE_W'(mag_x);
		nye = -PRE_W'(mag_y);
		x0  = mxe;
		y0  = nye;
		z0  = '0;
		if (mxe < 0) begin
			if (nye >= 0) begin
				x0 = nye;
				y0 = -mxe;
				z0 = ANG_QUARTER;
			end else begin
				x0 = -nye;
				y0 = mxe;
				z0 = -ANG_QUARTER;
			end
		end
	end

	// One CORDIC step; arithmetic shifts floor toward minus infinity.
	logic signed [X_W-1:0]   dx, dy;
	logic signed [ANG_W-1:0] tab;

	assign dx  = y_q >>> cmd.idx;
	assign dy  = x_q >>> cmd.idx;
	assign tab = atan_entry(cmd.idx);

	// Map the angle to a full circle and round to heading units.
	logic signed [ANG_W-1:0] zp, zr;
	logic [SUM_W-1:0]        h, m_d;

	always_comb begin
		zp  = z_q[ANG_W-1] ? z_q + ANG_FULL : z_q;
		zr  = (zp + ANG_RND) >>> ANG_SH;
		h   = SUM_W'(zr);
		m_d = (h >= FULL_U) ? h - FULL_U : h;
		if (zero_q) begin
			m_d = '0;
		end
	end

	// Unwrap against the stored heading, then form the difference to weight.
	logic [SUM_W-1:0]        g, mu_d, gu;
	logic signed [SUM_W+1:0] diff;
	logic signed [D_W-1:0]   d_d;

	always_comb begin
		g    = SUM_W'(heading_q);
		diff = signed'({2'b00, m_q}) - signed'({2'b00, g});
		mu_d = m_q;
		gu   = g;
		if (diff < -HALF_S) begin
			mu_d = m_q + FULL_U;
		end else if (diff > HALF_S) begin
			gu = g + FULL_U;
		end
		d_d = signed'({1'b0, gu}) - signed'({1'b0, mu_d});
	end

	// m*(1-w) + g*w is formed as m + (g-m)*w with a single multiplier.
	logic signed [P_W-1:0] prod_d;
	logic signed [A_W-1:0] acc;
	logic [Y_W-1:0]        yb, yw;
	logic [HEAD_W-1:0]     head_d;

	assign prod_d = P_W'(d_q) * P_W'(signed'({1'b0, wgt_q}));

	always_comb begin
		acc = (A_W'(signed'({1'b0, mu_q})) <<< WGT_W) + A_W'(prod_q) + BLEND_RND;
		yb  = Y_W'(acc >>> WGT_W);
		yw  = (yb > Y_W'(FULL)) ? yb - Y_W'(FULL) : yb;
		head_d = mode_q ? HEAD_W'(yw) : HEAD_W'(m_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= X_W'(x0) <<< PRE_SH;
			y_q    <= X_W'(y0) <<< PRE_SH;
			z_q    <= z0;
			zero_q <= (mag_x == '0) && (mag_y == '0);
			mode_q <= mode;
		end else if (cmd.iter) begin
			if (y_q < 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab;
			end
		end
		if (cmd.map) begin
			m_q <= m_d;
		end
		if (cmd.unwrap) begin
			mu_q <= mu_d;
			d_q  <= d_d;
		end
		if (cmd.mul) begin
			prod_q <= prod_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			wgt_q     <= WGT_RESET;
		end else begin
			if (cmd.commit) begin
				heading_q <= head_d;
			end
			if (wgt_we) begin
				wgt_q <= wgt_data;
			end
		end
	end

	assign yaw = heading_q;

`ifndef SYNTHESIS
	a_map_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map |=> m_q < FULL_U)
		else $error("magnetic heading outside one full circle");
	a_unwrap_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unwrap |=> d_q <= D_W'(HALF) && d_q >= -D_W'(HALF))
		else $error("unwrapped headings differ by more than half a circle");
	a_blend_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && mode_q |-> !acc[A_W-1])
		else $error("blend sum negative");
`endif

endmodule
`default_nettype wire
